[design/selective_repeat_reorder_receiver_assert.svh]
// assertion macros for the selective repeat reorder receiver
`ifndef SELECTIVE_REPEAT_REORDER_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_REORDER_RECEIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRR_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SRR_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SRR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[design/srr_pkg.sv]
// shared types for the selective repeat reorder receiver
`timescale 1ns / 1ps
`default_nettype none
package srr_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIST,
		ST_HOLD,
		ST_SCAN,
		ST_DELIV,
		ST_ACK
	} srr_state_t;
	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;
	// sequence space and payload cap are fixed by the protocol
	localparam int SEQ_SPACE   = 32768;
	localparam int MAX_PAYLOAD = 1024;
endpackage
`default_nettype wire

[design/selective_repeat_reorder_receiver.sv]
// top level: segment receive, history check, reorder store and drain sequencer
//
//  channel | signals                                        | dir
//  cfg     | cfg_we, cfg_data                               | in
//  in      | in_valid, in_ready, seg_seqno, payload_len     | in
//  out     | out_valid, out_ready, kind, out_seqno, out_len, dropped, last | out
//
// one segment is accepted in idle, then the history scan runs over the history count
// entries (HISTORY_DEPTH when full), a free slot search and a scan per drained
// segment run over up to HOLD_DEPTH entries, and a final scan of the store ends in a
// miss (one compare a cycle over the reorder store); each result beat waits for
// out_ready. in_ready is high only in idle; a stalled output holds the sequencer.
// reset clears valid bits, history count and head; store contents stay unset.
`timescale 1ns / 1ps
`default_nettype none
`include "selective_repeat_reorder_receiver_assert.svh"
module selective_repeat_reorder_receiver import srr_pkg::*; #(
	parameter int HISTORY_DEPTH = 32,
	parameter int HOLD_DEPTH    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] seg_seqno,
	input  wire logic [10:0] payload_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [15:0]      out_seqno,
	output logic [10:0]      out_len,
	output logic             dropped,
	output logic             last
);
	localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int DW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int BW = 6;
	localparam logic [16:0] SPACE = 17'(SEQ_SPACE);
	localparam logic [10:0] MAXP = 11'(MAX_PAYLOAD);
	localparam logic [BW-1:0] BUDGET = 6'd32;

	srr_state_t state_q, state_d;
	logic [15:0] base_q, seq_q;
	logic [10:0] len_q;
	logic drop_q;
	logic [HW-1:0] hidx_q, head_q;
	logic [CW-1:0] count_q;
	logic [DW-1:0] sidx_q;
	logic [BW-1:0] nres_q;
	logic [15:0] recent_q [HISTORY_DEPTH];
	logic [15:0] hseq_q [HOLD_DEPTH];
	logic [10:0] hlen_q [HOLD_DEPTH];
	logic [HOLD_DEPTH-1:0] hvalid_q;
	logic [15:0] dseq_q;
	logic [10:0] dlen_q;
	logic ov_q;

	logic in_beat, out_beat;
	logic [10:0] len_sat;
	logic [16:0] sum;
	logic [15:0] adv_base;
	logic hist_hit, hist_end, scan_hit, scan_end;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;
	assign len_sat  = (payload_len > MAXP) ? MAXP : payload_len;
	assign hist_hit = ({{(CW-HW){1'b0}}, hidx_q} < count_q) && (recent_q[hidx_q] == seq_q);
	assign hist_end = ({{(CW-HW){1'b0}}, hidx_q} >= count_q) ||
		(hidx_q == HW'(HISTORY_DEPTH - 1));
	assign scan_hit = hvalid_q[sidx_q] && (hseq_q[sidx_q] == base_q);
	assign scan_end = (sidx_q == DW'(HOLD_DEPTH - 1));

	// adder for the expected base, one subtract of the space
	always_comb begin
		sum = {1'b0, base_q} + {6'd0, dlen_q};
		adv_base = (sum >= SPACE) ? 16'(sum - SPACE) : sum[15:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_HIST;
			ST_HIST: begin
				if (hist_hit) state_d = ST_SCAN;
				else if (hist_end) state_d = (seq_q == base_q) ? ST_DELIV : ST_HOLD;
			end
			ST_HOLD:  if (!hvalid_q[sidx_q] || scan_end) state_d = ST_SCAN;
			ST_SCAN: begin
				if (nres_q >= BUDGET) state_d = ST_ACK;
				else if (scan_hit) state_d = ST_DELIV;
				else if (scan_end) state_d = ST_ACK;
			end
			ST_DELIV: if (out_ready) state_d = ST_SCAN;
			ST_ACK:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_DELIV) || (state_q == ST_ACK);
		kind      = (state_q == ST_ACK) ? KIND_ACK : KIND_DELIVER;
		out_seqno = (state_q == ST_ACK) ? seq_q : dseq_q;
		out_len   = (state_q == ST_ACK) ? 11'd0 : dlen_q;
		dropped   = (state_q == ST_ACK) && drop_q;
		last      = (state_q == ST_ACK);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			base_q   <= 16'd0;
			count_q  <= '0;
			head_q   <= '0;
			hvalid_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) base_q <= (cfg_data >= SPACE[15:0]) ?
				16'(cfg_data - SPACE[15:0]) : cfg_data;
			if (state_q == ST_HIST && !hist_hit && hist_end) begin
				head_q <= (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
				if (count_q < CW'(HISTORY_DEPTH)) count_q <= count_q + 1'b1;
				if (seq_q == base_q) ov_q <= 1'b1;
			end
			if (state_q == ST_HOLD && !hvalid_q[sidx_q]) hvalid_q[sidx_q] <= 1'b1;
			if (state_q == ST_SCAN && nres_q < BUDGET && scan_hit) begin
				hvalid_q[sidx_q] <= 1'b0;
				ov_q <= 1'b1;
			end
			if (state_q == ST_DELIV && out_ready && ov_q) begin
				base_q <= adv_base;
			end
			if (state_q == ST_DELIV && out_ready) ov_q <= 1'b0;
		end
	end

	// datapath registers and stores
	always_ff @(posedge clk) begin
		if (in_beat) begin
			seq_q   <= seg_seqno;
			len_q   <= len_sat;
			drop_q  <= 1'b0;
			hidx_q  <= '0;
			sidx_q  <= '0;
			nres_q  <= '0;
		end
		if (state_q == ST_HIST) begin
			hidx_q <= hidx_q + 1'b1;
			if (!hist_hit && hist_end) begin
				recent_q[head_q] <= seq_q;
				sidx_q <= '0;
				if (seq_q == base_q) begin
					dseq_q <= seq_q;
					dlen_q <= len_q;
					nres_q <= 6'd1;
				end
			end
		end
		if (state_q == ST_HOLD) begin
			if (!hvalid_q[sidx_q]) begin
				hseq_q[sidx_q] <= seq_q;
				hlen_q[sidx_q] <= len_q;
				sidx_q <= '0;
			end else if (scan_end) begin
				drop_q <= 1'b1;
				sidx_q <= '0;
			end else sidx_q <= sidx_q + 1'b1;
		end
		if (state_q == ST_SCAN) begin
			if (scan_hit && nres_q < BUDGET) begin
				dseq_q <= hseq_q[sidx_q];
				dlen_q <= hlen_q[sidx_q];
				nres_q <= nres_q + 1'b1;
				sidx_q <= '0;
			end else sidx_q <= scan_end ? '0 : sidx_q + 1'b1;
		end
	end

	`SRR_ASSERT_NEXT(a_ack_idle, clk, arst_n, (state_q == ST_ACK && out_ready), in_ready, "ack not followed by idle")
	`SRR_ASSERT_IMPL(a_busy, clk, arst_n, (out_valid |-> !in_ready), "ready while result pending")
	`SRR_ASSERT_IMPL(a_last, clk, arst_n, (out_valid && last |-> kind == KIND_ACK), "last on deliver")
	`SRR_ASSERT_IMPL(a_budget, clk, arst_n, (out_valid && !last |-> nres_q <= BUDGET), "result budget exceeded")
endmodule
`default_nettype wire

[tb/testbench.sv]
// testbench for the selective repeat reorder receiver
`timescale 1ns / 1ps
module testbench;
	import srr_pkg::*;

	localparam int SPACE = 32768;
	localparam int HIST_N = 32;
	localparam int STORE_N = 32;
	localparam int PAY_MAX = 1024;
	localparam int DRAIN_CAP = 32;

	typedef struct packed {
		logic        kind;
		logic [15:0] seqno;
		logic [10:0] len;
		logic        dropped;
		logic        last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] seg_seqno = '0;
	logic [10:0] payload_len = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [15:0] out_seqno;
	logic [10:0] out_len;
	logic dropped;
	logic last;

	selective_repeat_reorder_receiver dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .seg_seqno(seg_seqno),
		.payload_len(payload_len), .out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .out_seqno(out_seqno), .out_len(out_len),
		.dropped(dropped), .last(last)
	);

	always #5 clk = ~clk;

	// receiver copy of the block state
	logic [15:0] next_expected;
	logic [15:0] store_seq [STORE_N];
	logic [10:0] store_len [STORE_N];
	logic        store_used [STORE_N];
	logic [15:0] seen_seq [HIST_N];
	int          seen_count;
	int          seen_head;

	beat_t pending_beats [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_cycles = 0;

	// queue one expected beat at the tail
	task automatic add_beat(input beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endtask

	// expected beats for one segment
	task automatic predict_segment(input logic [15:0] seq, input logic [10:0] len_in);
		logic [10:0] len;
		logic dup;
		logic drop;
		logic hit;
		int n;
		len = (len_in > PAY_MAX) ? 11'(PAY_MAX) : len_in;
		dup = 1'b0;
		drop = 1'b0;
		n = 0;
		for (int i = 0; i < seen_count; i++)
			if (seen_seq[i] == seq) dup = 1'b1;
		if (!dup) begin
			seen_seq[seen_head] = seq;
			seen_head = (seen_head + 1) % HIST_N;
			if (seen_count < HIST_N) seen_count++;
			if (seq == next_expected) begin
				add_beat(beat_t'{KIND_DELIVER, seq, len, 1'b0, 1'b0});
				n++;
				next_expected = 16'((32'(next_expected) + len) % SPACE);
			end else begin
				drop = 1'b1;
				for (int i = 0; i < STORE_N; i++)
					if (drop && !store_used[i]) begin
						store_used[i] = 1'b1;
						store_seq[i] = seq;
						store_len[i] = len;
						drop = 1'b0;
					end
			end
		end
		// drain in-order held segments up to the budget
		do begin
			hit = 1'b0;
			if (n < DRAIN_CAP) begin
				for (int i = 0; i < STORE_N; i++)
					if (!hit && store_used[i] && store_seq[i] == next_expected) begin
						add_beat(beat_t'{KIND_DELIVER, store_seq[i], store_len[i],
							1'b0, 1'b0});
						store_used[i] = 1'b0;
						n++;
						next_expected = 16'((32'(next_expected) + store_len[i]) % SPACE);
						hit = 1'b1;
					end
			end
		end while (hit);
		add_beat(beat_t'{KIND_ACK, seq, 11'd0, drop, 1'b1});
	endtask

	// send one segment beat
	task automatic send_segment(input logic [15:0] seq, input logic [10:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		seg_seqno <= seq;
		payload_len <= len;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_segment(seq, len);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_base(input logic [15:0] base);
		wait_drained();
		cfg_data <= base;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		next_expected = 16'(base % SPACE);
	endtask

	// receiver readiness
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result beat
	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, out_seqno, out_len, dropped, last};
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %p", got);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
				end
			end
		end
	end

	task automatic test_directed();
		write_base(16'd100);
		send_segment(16'd100, 11'd0);
		send_segment(16'd100, 11'd5);
		send_segment(16'd110, 11'd7);
		send_segment(16'd105, 11'd5);
		send_segment(16'd117, 11'h7FF);
		send_segment(16'hFFFF, 11'd3);
		send_segment(16'h8000, 11'd1);
		send_segment(16'd1141, 11'd1024);
		write_base(16'hFFFF);
		send_segment(16'h7FFF, 11'd1);
		send_segment(16'h0000, 11'd1025);
		write_base(16'd0);
	endtask

	// fill the store beyond capacity, then send the base segment, a duplicate and a stray
	task automatic test_store_full();
		write_base(16'd0);
		for (int i = 34; i >= 1; i--) send_segment(16'(i * 10), 11'd10);
		send_segment(16'd0, 11'd10);
		send_segment(16'd0, 11'd10);
		send_segment(16'd5000, 11'd1);
	endtask

	// windows of shuffled in-order segments, plus noise
	task automatic test_random(input int items, input logic [15:0] base);
		logic [15:0] seqs [8];
		logic [10:0] lens [8];
		logic [15:0] cur;
		int k;
		int sent;
		write_base(base);
		cur = 16'(base % SPACE);
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) == 0) begin
				send_segment(16'($urandom), 11'($urandom));
				sent++;
			end else begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) begin
					seqs[i] = cur;
					lens[i] = ($urandom_range(19) == 0) ? 11'($urandom) :
						11'($urandom_range(1, 64));
					cur = 16'((32'(cur) + ((lens[i] > PAY_MAX) ? PAY_MAX : lens[i])) % SPACE);
				end
				for (int i = k - 1; i > 0; i--) begin
					int j;
					logic [15:0] ts;
					logic [10:0] tl;
					j = $urandom_range(i);
					ts = seqs[i]; seqs[i] = seqs[j]; seqs[j] = ts;
					tl = lens[i]; lens[i] = lens[j]; lens[j] = tl;
				end
				for (int i = 0; i < k; i++) begin
					send_segment(seqs[i], lens[i]);
					if ($urandom_range(7) == 0) send_segment(seqs[i], lens[i]);
				end
				sent += k;
				if (cur == base % SPACE) cur = cur + 16'd1;
			end
		end
	endtask

	// receiver stalls long while the sender keeps offering
	task automatic test_backpressure();
		write_base(16'd200);
		hold_off_cycles = 3000;
		for (int i = 0; i < 20; i++) send_segment(16'(200 + i), 11'd1);
		wait_drained();
		send_segment(16'd220, 11'd2);
	endtask

	initial begin
		next_expected = '0;
		seen_count = 0;
		seen_head = 0;
		for (int i = 0; i < STORE_N; i++) store_used[i] = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		send_idle_pct = 12; recv_idle_pct = 67;
		test_random(100, 16'd0);
		send_idle_pct = 67; recv_idle_pct = 12;
		test_random(100, 16'h7F00);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(70, 16'd12345);
		test_backpressure();
		wait_drained();
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("[selective_repeat_reorder_receiver] OK");
		end else begin
			$display("[selective_repeat_reorder_receiver] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#50ms;
		$display("[selective_repeat_reorder_receiver] ERROR");
		$finish;
	end
endmodule
